/* hdl/sde_pkg.sv */
`default_nettype none

package sde_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int BYTE_W      = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] ESCAPE_BYTE = 8'h80;
    localparam logic [BYTE_W-1:0] PAD_BYTE    = 8'h00;
    localparam int                DELTA_LIMIT = 127;

    // Input request kinds.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    // Commands handed from the classifier to the byte emitter.
    typedef enum logic [1:0] {
        OP_PLAIN   = 2'd0,
        OP_ESC     = 2'd1,
        OP_ESC_PAD = 2'd2,
        OP_SUM     = 2'd3
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [SAMPLE_W-1:0] data;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

/* hdl/sde_if.sv */
`default_nettype none

interface sde_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] sample;

    modport source (output valid, output req_type, output sample, input ready);
    modport sink   (input valid, input req_type, input sample, output ready);
endinterface

interface sde_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

/* hdl/sde_front.sv */
`default_nettype none

module sde_front (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_ready,
    input  wire                         i_req_type,
    input  wire [15:0]                  i_sample,
    input  wire sde_pkg::t_queue_status i_status,
    output logic                        o_push,
    output sde_pkg::t_cmd               o_cmd
);

    logic [15:0] r_prev;
    logic [15:0] r_sum;
    logic        r_parity;
    logic [15:0] n_prev;
    logic [15:0] n_sum;
    logic        n_parity;
    logic [15:0] diff;
    logic        small_delta;
    logic        accept;

    assign o_ready = !i_status.full;
    assign accept  = i_valid && !i_status.full;
    assign o_push  = accept;
    assign diff    = i_sample - r_prev;

    // The difference of -128 is deliberately escaped.
    assign small_delta = ($signed(diff) <= $signed(16'(sde_pkg::DELTA_LIMIT)))
                      && ($signed(diff) >= -$signed(16'(sde_pkg::DELTA_LIMIT)));

    always_comb begin
        n_prev   = r_prev;
        n_sum    = r_sum;
        n_parity = r_parity;
        o_cmd.op   = sde_pkg::OP_PLAIN;
        o_cmd.data = diff;
        if (i_req_type == sde_pkg::REQ_FINISH) begin
            o_cmd.op   = sde_pkg::OP_SUM;
            o_cmd.data = r_sum;
            n_prev     = '0;
            n_sum      = '0;
            n_parity   = 1'b0;
        end else begin
            n_prev = i_sample;
            n_sum  = r_sum + i_sample;
            if (small_delta) begin
                o_cmd.op = sde_pkg::OP_PLAIN;
                n_parity = !r_parity;
            end else begin
                // A pad is needed only when the escape byte leaves the count odd.
                o_cmd.op   = r_parity ? sde_pkg::OP_ESC : sde_pkg::OP_ESC_PAD;
                o_cmd.data = i_sample;
                n_parity   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_sum    <= '0;
            r_parity <= 1'b0;
        end else if (accept) begin
            r_prev   <= n_prev;
            r_sum    <= n_sum;
            r_parity <= n_parity;
        end
    end

endmodule

`default_nettype wire

/* hdl/sde_queue.sv */
`default_nettype none

module sde_queue (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_push,
    input  wire sde_pkg::t_cmd          i_cmd,
    input  wire                         i_pop,
    output sde_pkg::t_cmd               o_head,
    output sde_pkg::t_queue_status      o_status
);

    sde_pkg::t_cmd                      r_mem [sde_pkg::QUEUE_DEPTH];
    logic [sde_pkg::QUEUE_PTR_W-1:0]    r_wr_ptr;
    logic [sde_pkg::QUEUE_PTR_W-1:0]    r_rd_ptr;
    logic [sde_pkg::QUEUE_CNT_W-1:0]    r_count;
    logic                               do_push;
    logic                               do_pop;

    assign o_status.full  = (r_count == sde_pkg::QUEUE_CNT_W'(sde_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/sde_back.sv */
`default_nettype none

module sde_back (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire sde_pkg::t_cmd          i_head,
    input  wire sde_pkg::t_queue_status i_status,
    output logic                        o_pop,
    output logic                        o_valid,
    input  wire                         i_ready,
    output logic [7:0]                  o_out_byte,
    output logic                        o_last
);

    logic [1:0] r_step;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic [7:0] sel_byte;
    logic       sel_last;
    logic       load;

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_last     = r_last;

    // The output register takes the next byte of the head command whenever it is empty or being drained.
    assign load  = !i_status.empty && (!r_valid || i_ready);
    assign o_pop = load && sel_last;

    always_comb begin
        sel_byte = i_head.data[7:0];
        sel_last = 1'b0;
        unique case (i_head.op)
            sde_pkg::OP_PLAIN: begin
                sel_byte = i_head.data[7:0];
                sel_last = 1'b1;
            end
            sde_pkg::OP_ESC: begin
                unique case (r_step)
                    2'd0:    sel_byte = sde_pkg::ESCAPE_BYTE;
                    2'd1:    sel_byte = i_head.data[15:8];
                    default: begin
                        sel_byte = i_head.data[7:0];
                        sel_last = 1'b1;
                    end
                endcase
            end
            sde_pkg::OP_ESC_PAD: begin
                unique case (r_step)
                    2'd0:    sel_byte = sde_pkg::ESCAPE_BYTE;
                    2'd1:    sel_byte = sde_pkg::PAD_BYTE;
                    2'd2:    sel_byte = i_head.data[15:8];
                    default: begin
                        sel_byte = i_head.data[7:0];
                        sel_last = 1'b1;
                    end
                endcase
            end
            default: begin
                if (r_step == 2'd0) begin
                    sel_byte = i_head.data[15:8];
                end else begin
                    sel_byte = i_head.data[7:0];
                    sel_last = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= sel_byte;
            r_last <= sel_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_step  <= sel_last ? 2'd0 : r_step + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/sample_delta_escape_encoder_top.sv */
// Flow: an accepted word is written into the command queue; the emitter loads its bytes in
// turn into the output register when it is free. Rates: the input takes one word a cycle
// while the four-entry command queue has room; the emitter delivers one byte a cycle while
// the output is ready and a command is queued, and a word yields one to four bytes.
// Reset: synchronous, active low; clears the previous sample, the checksum, the parity,
// the queue and the output valid flag and byte step. No clearing pass is needed.
`default_nettype none

module sample_delta_escape_encoder_top (
    input  wire       i_clk,
    input  wire       i_rst_n,
    sde_in_if.sink    i_in,
    sde_out_if.source o_out
);

    sde_pkg::t_cmd          push_cmd;
    sde_pkg::t_cmd          head_cmd;
    sde_pkg::t_queue_status q_status;
    logic                   push;
    logic                   pop;
    logic                   in_ready;
    logic                   out_valid;
    logic [7:0]             out_byte;
    logic                   out_last;

    assign i_in.ready     = in_ready;
    assign o_out.valid    = out_valid;
    assign o_out.out_byte = out_byte;
    assign o_out.last     = out_last;

    sde_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .o_ready    (in_ready),
        .i_req_type (i_in.req_type),
        .i_sample   (i_in.sample),
        .i_status   (q_status),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    sde_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_head   (head_cmd),
        .o_status (q_status)
    );

    sde_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_cmd),
        .i_status   (q_status),
        .o_pop      (pop),
        .o_valid    (out_valid),
        .i_ready    (o_out.ready),
        .o_out_byte (out_byte),
        .o_last     (out_last)
    );

endmodule

`default_nettype wire

/* sim/sde_checker.sv */
`timescale 1ns / 1ps

module sde_checker (
    input  wire i_clk,
    input  wire i_rst_n,
    sde_in_if   i_in_mon,
    sde_out_if  i_out_mon,
    output int  o_errors,
    output int  o_pending,
    output int  o_bytes_checked,
    output int  o_escapes,
    output int  o_pads
);

    typedef struct packed {
        logic [sde_pkg::BYTE_W-1:0] out_byte;
        logic                       last;
    } t_coded_byte;

    t_coded_byte                  coded_q[$];
    t_coded_byte                  want;
    logic [sde_pkg::SAMPLE_W-1:0] prev_sample = '0;
    logic [sde_pkg::SAMPLE_W-1:0] checksum    = '0;
    logic                         odd_count   = 1'b0;
    int                           error_cnt   = 0;
    int                           checked_cnt = 0;
    int                           escape_cnt  = 0;
    int                           pad_cnt     = 0;

    task automatic emit(input logic [sde_pkg::BYTE_W-1:0] value, input logic is_last);
        coded_q.push_back('{out_byte: value, last: is_last});
    endtask

    // Works out the bytes that one accepted word must produce.
    task automatic encode_word(input logic kind, input logic [sde_pkg::SAMPLE_W-1:0] smp);
        logic [sde_pkg::SAMPLE_W-1:0] delta;
        int                           sdelta;
        if (kind == sde_pkg::REQ_FINISH) begin
            emit(checksum[15:8], 1'b0);
            emit(checksum[7:0], 1'b1);
            prev_sample = '0;
            checksum    = '0;
            odd_count   = 1'b0;
            return;
        end
        delta  = smp - prev_sample;
        sdelta = $signed(delta);
        // A difference of -128 is escaped as well, so 0x80 is never a plain delta.
        if (sdelta > sde_pkg::DELTA_LIMIT || sdelta < -sde_pkg::DELTA_LIMIT) begin
            escape_cnt++;
            emit(sde_pkg::ESCAPE_BYTE, 1'b0);
            odd_count = ~odd_count;
            if (odd_count) begin
                emit(sde_pkg::PAD_BYTE, 1'b0);
                odd_count = 1'b0;
                pad_cnt++;
            end
            emit(smp[15:8], 1'b0);
            emit(smp[7:0], 1'b1);
        end else begin
            emit(delta[7:0], 1'b1);
            odd_count = ~odd_count;
        end
        prev_sample = smp;
        checksum    = checksum + smp;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            coded_q.delete();
            prev_sample = '0;
            checksum    = '0;
            odd_count   = 1'b0;
        end else begin
            // Bytes never leave on the edge that accepts their word, so the pop comes first.
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (coded_q.size() == 0) begin
                    error_cnt++;
                    $error("unexpected byte: out_byte %02h, last %0b with nothing expected",
                           i_out_mon.out_byte, i_out_mon.last);
                end else begin
                    want = coded_q.pop_front();
                    checked_cnt++;
                    if (i_out_mon.out_byte !== want.out_byte) begin
                        error_cnt++;
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               want.out_byte, i_out_mon.out_byte);
                    end
                    if (i_out_mon.last !== want.last) begin
                        error_cnt++;
                        $error("last mismatch: expected %0b, actual %0b",
                               want.last, i_out_mon.last);
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                encode_word(i_in_mon.req_type, i_in_mon.sample);
            end
        end
        o_errors        <= error_cnt;
        o_pending       <= coded_q.size();
        o_bytes_checked <= checked_cnt;
        o_escapes       <= escape_cnt;
        o_pads          <= pad_cnt;
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_WORDS = 190;
    localparam int HOLD_CYCLES  = 80;
    localparam int TAIL_CYCLES  = 20;
    localparam int LIMIT_CYCLES = 200000;

    logic clk      = 1'b0;
    logic rst_n;
    logic calm     = 1'b0;
    logic hold_req = 1'b0;
    int   samples  = 0;
    int   finishes = 0;
    int   errors;
    int   pending;
    int   bytes_checked;
    int   escapes;
    int   pads;

    sde_in_if  in_ch();
    sde_out_if out_ch();

    sample_delta_escape_encoder_top DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sde_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_mon        (in_ch),
        .i_out_mon       (out_ch),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_bytes_checked (bytes_checked),
        .o_escapes       (escapes),
        .o_pads          (pads)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offers one word and waits until the block takes it.
    task automatic send_word(input logic kind, input logic [sde_pkg::SAMPLE_W-1:0] smp);
        int gap;
        if (!calm && $urandom_range(0, 99) < 10) begin
            gap = $urandom_range(1, 3);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.req_type <= kind;
        in_ch.sample   <= smp;
        do @(posedge clk); while (!in_ch.ready);
        if (kind == sde_pkg::REQ_FINISH) begin
            finishes++;
        end else begin
            samples++;
        end
    endtask

    // Output side: random back-pressure, none while calm, and one long hold-off.
    initial begin : byte_sink
        int   hold_left;
        logic held;
        hold_left = 0;
        held      = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (hold_req && !held) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end else if (calm) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= 10);
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : word_source
        logic [sde_pkg::SAMPLE_W-1:0] walk;
        logic [sde_pkg::SAMPLE_W-1:0] smp;
        int                           pick;
        int                           step;
        rst_n          <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.req_type <= sde_pkg::REQ_SAMPLE;
        in_ch.sample   <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Finish straight after reset gives a zero checksum.
        send_word(sde_pkg::REQ_FINISH, 16'hFFFF);
        send_word(sde_pkg::REQ_SAMPLE, 16'h0000);
        send_word(sde_pkg::REQ_SAMPLE, 16'h007F);
        send_word(sde_pkg::REQ_SAMPLE, 16'h0000);
        // Escape on an odd count, then a difference of -128 on an even count.
        send_word(sde_pkg::REQ_SAMPLE, 16'h0080);
        send_word(sde_pkg::REQ_SAMPLE, 16'h0000);
        send_word(sde_pkg::REQ_SAMPLE, 16'hFFFF);
        send_word(sde_pkg::REQ_SAMPLE, 16'h7FFF);
        send_word(sde_pkg::REQ_SAMPLE, 16'h8000);
        send_word(sde_pkg::REQ_SAMPLE, 16'h0000);
        send_word(sde_pkg::REQ_SAMPLE, 16'hAAAA);
        send_word(sde_pkg::REQ_SAMPLE, 16'h5555);
        send_word(sde_pkg::REQ_SAMPLE, 16'h5554);
        send_word(sde_pkg::REQ_FINISH, 16'h0000);
        send_word(sde_pkg::REQ_SAMPLE, 16'hFFFF);
        send_word(sde_pkg::REQ_SAMPLE, 16'h0081);
        send_word(sde_pkg::REQ_FINISH, 16'h5A5A);

        // Mostly a random walk with small steps, some jumps and the odd finish.
        walk = '0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            calm <= (n >= 60 && n < 110);
            if (n == 70) begin
                hold_req <= 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                send_word(sde_pkg::REQ_FINISH, sde_pkg::SAMPLE_W'($urandom));
                walk = '0;
            end else begin
                if (pick < 15) begin
                    case ($urandom_range(0, 3))
                        0:       step = sde_pkg::DELTA_LIMIT;
                        1:       step = -sde_pkg::DELTA_LIMIT;
                        2:       step = sde_pkg::DELTA_LIMIT + 1;
                        default: step = -sde_pkg::DELTA_LIMIT - 1;
                    endcase
                    smp = walk + sde_pkg::SAMPLE_W'(step);
                end else if (pick < 65) begin
                    step = $urandom_range(0, 2 * sde_pkg::DELTA_LIMIT);
                    smp  = walk + sde_pkg::SAMPLE_W'(step - sde_pkg::DELTA_LIMIT);
                end else begin
                    smp = sde_pkg::SAMPLE_W'($urandom);
                end
                send_word(sde_pkg::REQ_SAMPLE, smp);
                walk = smp;
            end
        end
        in_ch.valid <= 1'b0;
        calm        <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d samples and %0d finish words; %0d output bytes checked.",
                 samples, finishes, bytes_checked);
        $display("Escapes: %0d, with a pad byte: %0d; output held off once for %0d cycles.",
                 escapes, pads, HOLD_CYCLES);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
